FILE: src/rrfc_pkg.sv
`default_nettype none

package rrfc_pkg;

  typedef enum logic [1:0] {
    CMD_REQ   = 2'd0,
    CMD_RESP  = 2'd1,
    CMD_CLEAR = 2'd2,
    CMD_NOP   = 2'd3
  } cmd_t;

  typedef logic [7:0][7:0] hdr_t;
  typedef logic [16:0]     len_t;

  localparam logic [7:0] FN_RW_A = 8'h41;
  localparam logic [7:0] FN_RW_B = 8'h43;
  localparam logic [7:0] FN_DIAG = 8'h45;

  localparam int CTL_LONG_BIT = 3;

  localparam logic [2:0] OP_READ = 3'd0;
  localparam logic [2:0] OP_SET  = 3'd1;
  localparam logic [2:0] OP_AND  = 3'd3;
  localparam logic [2:0] OP_OR   = 3'd5;
  localparam logic [2:0] OP_XOR  = 3'd7;

  localparam logic [3:0] CLASS_UNKNOWN    = 4'd0;
  localparam logic [3:0] CLASS_SHORT_READ = 4'd1;
  localparam logic [3:0] CLASS_SHORT_SET  = 4'd2;
  localparam logic [3:0] CLASS_SHORT_XOR  = 4'd5;
  localparam logic [3:0] CLASS_LONG_READ  = 4'd6;
  localparam logic [3:0] CLASS_LONG_SET   = 4'd7;
  localparam logic [3:0] CLASS_LONG_XOR   = 4'd10;

  localparam len_t LEN_UNKNOWN_SUB = 17'd255;
  localparam len_t LEN_FIXED       = 17'd13;

  localparam int RES_W = 73;

  // expected response length for function 0x45, subcode in frame byte 2
  function automatic len_t sub45_length(hdr_t h, len_t len);
    len_t r;
    r = LEN_UNKNOWN_SUB;
    unique case (h[1])
      8'd0, 8'd1, 8'd2, 8'd3: r = 17'd9;
      8'd4:                   r = 17'd6 + len_t'(h[6]);
      8'd5, 8'd7, 8'd9, 8'd36: r = LEN_FIXED;
      8'd6:                   r = 17'd6 + len_t'(h[4]);
      8'd8:                   r = 17'd6 + len_t'(h[2]);
      8'd12:                  r = 17'd10 + len_t'(h[6]);
      8'd14:                  r = 17'd8 + len_t'(h[4]);
      8'd33, 8'd40:           r = len + 17'd2;
      8'd34, 8'd44, 8'd45:    r = len + 17'd1;
      8'd35:                  r = len + 17'd2 + len_t'(h[7]);
      8'd41:                  r = 17'd30;
      8'd43:                  r = len + 17'd24;
      default:                r = LEN_UNKNOWN_SUB;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

FILE: src/request_response_frame_checker.sv
// a result enters the registered output buffer when the frame's last byte is accepted
// throughput: one transaction per cycle while s_tready is high; a two-entry output buffer keeps s_tready high
// while one result waits, so bytes keep flowing under short output stalls
// reset: rst is synchronous; it clears the frame counter, header bytes, the stored
// class, length, address and size, and empties the output buffer
`default_nettype none

module request_response_frame_checker #(
  parameter int MAX_FRAME_BYTES = 256
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [7:0]  s_tdata,   // data_byte
  input  wire logic [1:0]  s_tuser,   // command
  input  wire logic        s_tlast,   // last
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [71:0]      m_tdata,   // packet_class, expected_length, target_addr,
                                      // data_size, too_short, addr_mismatch, size_mismatch
  output logic [0:0]       m_tuser    // result_kind
);

  localparam int PosW = $clog2(MAX_FRAME_BYTES + 1);

  logic [PosW-1:0]     byte_pos, byte_pos_next, frame_len;
  rrfc_pkg::hdr_t      hdr, hdr_next;
  logic [3:0]          class_code, class_code_next;
  rrfc_pkg::len_t      resp_len, resp_len_next;
  logic [31:0]         saved_addr, saved_addr_next;
  logic [15:0]         saved_size, saved_size_next;

  rrfc_pkg::cmd_t      cmd;
  logic                acc;
  logic                res_valid;
  logic [rrfc_pkg::RES_W-1:0] res_data, out_data;

  logic                too_short, addr_mis, size_mis;
  logic [7:0]          fn, ctl;
  logic                is_long;
  logic [31:0]         req_addr, rsp_addr_s, rsp_addr_l;
  logic [15:0]         req_size, rsp_size_s, rsp_size_l;
  logic [3:0]          class_base;
  rrfc_pkg::len_t      rd_extra, wr_extra;

  assign cmd = rrfc_pkg::cmd_t'(s_tuser);
  assign acc = s_tvalid && s_tready;

  assign frame_len = (byte_pos < PosW'(MAX_FRAME_BYTES)) ? byte_pos + PosW'(1) : byte_pos;

  // header with the current byte folded in
  always_comb begin
    for (int i = 0; i < 8; i++) begin
      hdr_next[i] = (byte_pos == '0) ? 8'h00 : hdr[i];
      if (byte_pos == PosW'(i + 1)) begin
        hdr_next[i] = s_tdata;
      end
    end
  end

  assign fn         = hdr_next[0];
  assign ctl        = hdr_next[1];
  assign is_long    = ctl[rrfc_pkg::CTL_LONG_BIT];
  assign req_addr   = is_long ? {hdr_next[2], hdr_next[3], hdr_next[4], hdr_next[5]}
                              : {16'h0000, hdr_next[2], hdr_next[3]};
  assign req_size   = is_long ? {hdr_next[7], hdr_next[6]} : {8'h00, hdr_next[4]};
  assign class_base = is_long ? rrfc_pkg::CLASS_LONG_READ : rrfc_pkg::CLASS_SHORT_READ;
  assign rd_extra   = is_long ? 17'd7 : 17'd6;
  assign wr_extra   = is_long ? 17'd11 : 17'd8;

  assign rsp_addr_s = {16'h0000, hdr_next[2], hdr_next[3]};
  assign rsp_size_s = {8'h00, hdr_next[4]};
  assign rsp_addr_l = {hdr_next[2], hdr_next[3], hdr_next[4], hdr_next[5]};
  assign rsp_size_l = {hdr_next[7], hdr_next[6]};

  always_comb begin
    byte_pos_next   = byte_pos;
    class_code_next = class_code;
    resp_len_next   = resp_len;
    saved_addr_next = saved_addr;
    saved_size_next = saved_size;
    too_short       = 1'b0;
    addr_mis        = 1'b0;
    size_mis        = 1'b0;
    res_valid       = 1'b0;

    unique case (cmd)
      rrfc_pkg::CMD_CLEAR: begin
        class_code_next = rrfc_pkg::CLASS_UNKNOWN;
        resp_len_next   = '0;
        saved_addr_next = '0;
        saved_size_next = '0;
      end
      rrfc_pkg::CMD_REQ, rrfc_pkg::CMD_RESP: begin
        byte_pos_next = s_tlast ? '0 : frame_len;
        res_valid     = s_tlast;
        if (s_tlast && cmd == rrfc_pkg::CMD_REQ) begin
          if (frame_len < PosW'(3)) begin
            too_short = 1'b1;
          end else if (fn == rrfc_pkg::FN_RW_A || fn == rrfc_pkg::FN_RW_B) begin
            saved_addr_next = req_addr;
            saved_size_next = req_size;
            unique case (ctl[2:0])
              rrfc_pkg::OP_READ: begin
                class_code_next = class_base;
                resp_len_next   = rrfc_pkg::len_t'(req_size) + rd_extra;
              end
              rrfc_pkg::OP_SET: begin
                class_code_next = class_base + 4'd1;
                resp_len_next   = rrfc_pkg::len_t'(req_size) + wr_extra;
              end
              rrfc_pkg::OP_AND: begin
                class_code_next = class_base + 4'd2;
                resp_len_next   = rrfc_pkg::len_t'(req_size) + wr_extra;
              end
              rrfc_pkg::OP_OR: begin
                class_code_next = class_base + 4'd3;
                resp_len_next   = rrfc_pkg::len_t'(req_size) + wr_extra;
              end
              rrfc_pkg::OP_XOR: begin
                class_code_next = class_base + 4'd4;
                resp_len_next   = rrfc_pkg::len_t'(req_size) + wr_extra;
              end
              default: begin
              end
            endcase
          end else if (fn == rrfc_pkg::FN_DIAG) begin
            resp_len_next = rrfc_pkg::sub45_length(hdr_next, rrfc_pkg::len_t'(frame_len));
          end
        end else if (s_tlast) begin
          // response: compare echoed fields against the stored request
          priority if (class_code == rrfc_pkg::CLASS_SHORT_READ) begin
            // a short read echoes its size in frame byte 3
            size_mis = ({8'h00, hdr_next[2]} != saved_size);
          end else if (class_code >= rrfc_pkg::CLASS_SHORT_SET &&
                       class_code <= rrfc_pkg::CLASS_SHORT_XOR) begin
            addr_mis = (rsp_addr_s != saved_addr);
            size_mis = (rsp_size_s != saved_size);
          end else if (class_code == rrfc_pkg::CLASS_LONG_READ) begin
            size_mis = ({hdr_next[3], hdr_next[2]} != saved_size);
          end else if (class_code >= rrfc_pkg::CLASS_LONG_SET &&
                       class_code <= rrfc_pkg::CLASS_LONG_XOR) begin
            addr_mis = (rsp_addr_l != saved_addr);
            size_mis = (rsp_size_l != saved_size);
          end else begin
          end
        end
      end
      default: begin
      end
    endcase
  end

  assign res_data = {cmd == rrfc_pkg::CMD_RESP, size_mis, addr_mis, too_short,
                     saved_size_next, saved_addr_next, resp_len_next, class_code_next};

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_pos   <= '0;
      hdr        <= '0;
      class_code <= rrfc_pkg::CLASS_UNKNOWN;
      resp_len   <= '0;
      saved_addr <= '0;
      saved_size <= '0;
    end else if (acc) begin
      byte_pos   <= byte_pos_next;
      if (cmd == rrfc_pkg::CMD_REQ || cmd == rrfc_pkg::CMD_RESP) begin
        hdr <= hdr_next;
      end
      class_code <= class_code_next;
      resp_len   <= resp_len_next;
      saved_addr <= saved_addr_next;
      saved_size <= saved_size_next;
    end
  end

  rrfc_skid #(
    .WIDTH(rrfc_pkg::RES_W)
  ) u_skid (
    .clk      (clk),
    .rst      (rst),
    .in_valid (acc && res_valid),
    .in_ready (s_tready),
    .in_data  (res_data),
    .out_valid(m_tvalid),
    .out_ready(m_tready),
    .out_data (out_data)
  );

  assign m_tdata = out_data[71:0];
  assign m_tuser = out_data[72:72];

  a_pos_bound: assert property (@(posedge clk) disable iff (rst)
    byte_pos <= PosW'(MAX_FRAME_BYTES))
    else $error("frame counter beyond maximum");

  a_last_rewinds: assert property (@(posedge clk) disable iff (rst)
    acc && s_tlast && (cmd == rrfc_pkg::CMD_REQ || cmd == rrfc_pkg::CMD_RESP)
    |=> byte_pos == '0)
    else $error("frame counter not rewound after last byte");

  a_clear: assert property (@(posedge clk) disable iff (rst)
    acc && cmd == rrfc_pkg::CMD_CLEAR
    |=> class_code == rrfc_pkg::CLASS_UNKNOWN && saved_addr == '0 && resp_len == '0)
    else $error("stored analysis not cleared");

  a_short_req: assert property (@(posedge clk) disable iff (rst)
    acc && s_tlast && cmd == rrfc_pkg::CMD_REQ && byte_pos < PosW'(2)
    |=> $stable(class_code) && $stable(saved_addr) && $stable(saved_size))
    else $error("short request changed stored analysis");

endmodule

`default_nettype wire

FILE: src/rrfc_skid.sv
`default_nettype none

module rrfc_skid #(
  parameter int WIDTH = 8
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire logic [WIDTH-1:0] in_data,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output logic [WIDTH-1:0]      out_data
);

  logic             sk_valid;
  logic [WIDTH-1:0] sk_data;
  logic             push;

  assign in_ready = !sk_valid;
  assign push     = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      sk_valid  <= 1'b0;
    end else if (out_ready || !out_valid) begin
      if (sk_valid) begin
        out_valid <= 1'b1;
        sk_valid  <= 1'b0;
      end else begin
        out_valid <= push;
      end
    end else if (push) begin
      sk_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_ready || !out_valid) begin
      if (sk_valid) begin
        out_data <= sk_data;
      end else if (push) begin
        out_data <= in_data;
      end
    end else if (push) begin
      sk_data <= in_data;
    end
  end

endmodule

`default_nettype wire
